@@ hdl/tnw_pkg.sv @@
// Shared types and constants for the TLV name segment walker.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps

package tnw_pkg;

    localparam int unsigned HDR_BYTES       = 4;
    localparam logic [14:0] MAX_SEG_RESET   = 15'd24;
    localparam logic [14:0] COUNT_MAX       = 15'h7FFF;
    localparam int unsigned FIFO_DEPTH      = 4;
    localparam int unsigned FIFO_AW         = 2;
    localparam int unsigned REG_MAX_SEGMENTS = 0;

    localparam logic KIND_EXTENT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_TYPE_HI = 3'd0,
        PH_TYPE_LO = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_VALUE   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       end_of_name;
    } name_beat_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] seg_offset;
        logic [16:0] seg_length;
        logic [14:0] seg_count;
        logic        truncated;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic                 no_room;
        logic [FIFO_AW:0]     level;
    } fifo_stat_t;

endpackage

@@ hdl/tnw_walker.sv @@
// Segment walker datapath: header phase tracking, offsets and counters.
// Depends on tnw_pkg; produces up to two results per accepted beat.
`timescale 1ns / 1ps

module tnw_walker #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  tnw_pkg::name_beat_t beat,
    input  logic [14:0]        max_segments,
    output tnw_pkg::push_t     push
);

    tnw_pkg::phase_t          phase_reg, phase_next, phase_step;
    logic [15:0]              pos_reg, pos_next;
    logic [15:0]              start_reg, start_next;
    logic [7:0]               len_hi_reg, len_hi_next;
    logic [LENGTH_BITS-1:0]   remain_reg, remain_next, remain_step;
    logic [14:0]              count_reg, count_next, count_step;
    logic [15:0]              assembled;
    logic [LENGTH_BITS-1:0]   seg_len;
    logic                     report;
    tnw_pkg::result_t         extent, summary;

    assign assembled = {len_hi_reg, beat.name_byte};
    assign seg_len   = assembled[LENGTH_BITS-1:0];
    assign report    = (phase_reg == tnw_pkg::PH_LEN_LO) && (count_reg < max_segments);

    always_comb
    begin
        remain_step = remain_reg;
        case (phase_reg)
            tnw_pkg::PH_TYPE_HI: phase_step = tnw_pkg::PH_TYPE_LO;
            tnw_pkg::PH_TYPE_LO: phase_step = tnw_pkg::PH_LEN_HI;
            tnw_pkg::PH_LEN_HI:  phase_step = tnw_pkg::PH_LEN_LO;
            tnw_pkg::PH_LEN_LO:
            begin
                if (seg_len == '0)
                begin
                    phase_step = tnw_pkg::PH_TYPE_HI;
                end
                else
                begin
                    phase_step  = tnw_pkg::PH_VALUE;
                    remain_step = seg_len;
                end
            end
            default:
            begin
                if (remain_reg != '0)
                begin
                    remain_step = remain_reg - 1'b1;
                end
                if (remain_step == '0)
                begin
                    phase_step = tnw_pkg::PH_TYPE_HI;
                end
                else
                begin
                    phase_step = tnw_pkg::PH_VALUE;
                end
            end
        endcase
    end

    always_comb
    begin
        start_next  = start_reg;
        len_hi_next = len_hi_reg;
        count_step  = count_reg;
        if (phase_reg == tnw_pkg::PH_TYPE_HI)
        begin
            start_next = pos_reg;
        end
        if (phase_reg == tnw_pkg::PH_LEN_HI)
        begin
            len_hi_next = beat.name_byte;
        end
        if ((phase_reg == tnw_pkg::PH_LEN_LO) && (count_reg < tnw_pkg::COUNT_MAX))
        begin
            count_step = count_reg + 1'b1;
        end

        extent.result_kind = tnw_pkg::KIND_EXTENT;
        extent.seg_offset  = start_reg;
        extent.seg_length  = 17'(seg_len) + 17'(tnw_pkg::HDR_BYTES);
        extent.seg_count   = count_step;
        extent.truncated   = 1'b0;
        extent.last        = ~beat.end_of_name;

        summary.result_kind = tnw_pkg::KIND_SUMMARY;
        summary.seg_offset  = '0;
        summary.seg_length  = '0;
        summary.seg_count   = count_step;
        summary.truncated   = (phase_step != tnw_pkg::PH_TYPE_HI);
        summary.last        = 1'b1;

        push.num    = 2'd0;
        push.first  = extent;
        push.second = summary;
        if (accept)
        begin
            if (report && beat.end_of_name)
            begin
                push.num = 2'd2;
            end
            else if (report)
            begin
                push.num = 2'd1;
            end
            else if (beat.end_of_name)
            begin
                push.num   = 2'd1;
                push.first = summary;
            end
        end

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        if (accept)
        begin
            if (beat.end_of_name)
            begin
                phase_next  = tnw_pkg::PH_TYPE_HI;
                pos_next    = '0;
                remain_next = '0;
                count_next  = '0;
                start_next  = '0;
                len_hi_next = '0;
            end
            else
            begin
                phase_next  = phase_step;
                pos_next    = pos_reg + 1'b1;
                remain_next = remain_step;
                count_next  = count_step;
            end
        end
        else
        begin
            start_next  = start_reg;
            len_hi_next = len_hi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= tnw_pkg::PH_TYPE_HI;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_hi_reg <= '0;
            remain_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_hi_reg <= len_hi_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/tnw_result_fifo.sv @@
// Result queue: takes up to two results per cycle, delivers one per beat.
// Depends on tnw_pkg for the result and status types.
`timescale 1ns / 1ps

module tnw_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tnw_pkg::push_t       push,
    input  logic                 pop,
    output logic                 valid,
    output tnw_pkg::result_t     head,
    output tnw_pkg::fifo_stat_t  stat
);

    localparam int unsigned AW = tnw_pkg::FIFO_AW;

    tnw_pkg::result_t mem [tnw_pkg::FIFO_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      level_reg, level_next;
    logic [AW-1:0]    wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign valid        = (level_reg != '0);
    assign head         = mem[rd_ptr_reg];
    assign stat.level   = level_reg;
    assign stat.no_room = (level_reg > (AW+1)'(tnw_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.num);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        level_next  = level_reg + (AW+1)'(push.num) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

@@ hdl/tlv_name_segment_walker_core.sv @@
// Top level of the TLV name segment walker: register port, walker, result queue.
// Depends on tnw_pkg, tnw_walker and tnw_result_fifo.
//
// Usage: name bytes enter on the beat channel (beat_valid, beat_stall, beat_data),
// one byte per beat, with end_of_name set on the last byte of a name. Each
// complete segment header yields an extent result while the segment count is
// below max_segments, and the last byte also yields a summary result. Results
// leave on the result channel (result_valid, result_stall, result_data).
// An accepted byte's results are registered in the queue and offered from there.
// A byte is taken every cycle unless beat_stall is set; a byte that yields both
// an extent and a summary needs two result beats, so the queue of four entries
// absorbs the extra one. The beat channel stalls while the queue holds three or
// more results, which happens only when the receiver stalls.
// At reset the queue is empty, the walk starts at a fresh name and
// max_segments returns to 24. The register is written through the APB-style port
// at address 0 and should only be changed while no name is in flight.
`timescale 1ns / 1ps

module tlv_name_segment_walker_core #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 beat_valid,
    output logic                 beat_stall,
    input  tnw_pkg::name_beat_t  beat_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output tnw_pkg::result_t     result_data
);

    logic [14:0]          max_seg_reg, max_seg_next;
    logic                 reg_hit;
    logic                 beat_accept;
    logic                 result_pop;
    tnw_pkg::push_t       push;
    tnw_pkg::fifo_stat_t  fifo_stat;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'(tnw_pkg::REG_MAX_SEGMENTS));
    assign prdata  = reg_hit ? {17'd0, max_seg_reg} : 32'd0;

    always_comb
    begin
        max_seg_next = max_seg_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            max_seg_next = pwdata[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_seg_reg <= tnw_pkg::MAX_SEG_RESET;
        end
        else
        begin
            max_seg_reg <= max_seg_next;
        end
    end

    assign beat_stall  = fifo_stat.no_room;
    assign beat_accept = beat_valid && !beat_stall;
    assign result_pop  = result_valid && !result_stall;

    tnw_walker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (beat_accept),
        .beat         (beat_data),
        .max_segments (max_seg_reg),
        .push         (push)
    );

    tnw_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (result_pop),
        .valid (result_valid),
        .head  (result_data),
        .stat  (fifo_stat)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.level <= 3'(tnw_pkg::FIFO_DEPTH))
        else $error("result queue level beyond its depth");

    a_eon_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        beat_accept && beat_data.end_of_name |=> result_valid)
        else $error("end of name gave no result");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.result_kind == tnw_pkg::KIND_SUMMARY)
        |-> result_data.last)
        else $error("summary result without last");

    a_extent_untruncated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.result_kind == tnw_pkg::KIND_EXTENT)
        |-> !result_data.truncated)
        else $error("extent result flagged truncated");

endmodule
